>>> rtl/core/pida_pkg.sv
// Shared types and constants for the positional insert/delete list.
`timescale 1ns / 1ps

package pida_pkg;

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int EIDX_W   = 5;
    localparam int COUNT_W  = 6;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic dump_step;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_dump;
        logic empty;
        logic dump_last;
    } t_dp_status;

endpackage

>>> rtl/core/positional_insert_delete_array.sv
// Insert, delete and dump of an ordered list of up to DEPTH values (top level).
// Insert and delete: operands load at start, busy covers execute, then the result is strobed.
// Dump: after execute, each stored entry is strobed in order; an empty list gives STATUS_EMPTY.
// All cells shift or rotate together in parallel; the dump reads the head cell each step.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// Results cannot be stalled: each strobed result is valid for exactly one cycle.
`timescale 1ns / 1ps

module positional_insert_delete_array #(
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [pida_pkg::MODE_W-1:0]            i_mode,
    input  logic [pida_pkg::INDEX_W-1:0]           i_index,
    input  logic signed [pida_pkg::VALUE_W-1:0]    i_value,
    output logic                                   o_strobe,
    output logic [pida_pkg::STATUS_W-1:0]          o_status,
    output logic signed [pida_pkg::VALUE_W-1:0]    o_element,
    output logic [pida_pkg::EIDX_W-1:0]            o_element_index,
    output logic [pida_pkg::COUNT_W-1:0]           o_count,
    output logic                                   o_last
);

    pida_pkg::t_cmd       cmd;
    pida_pkg::t_dp_status dp_status;

    pida_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    pida_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status_dp     (dp_status),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_element       (o_element),
        .o_element_index (o_element_index),
        .o_count         (o_count),
        .o_last          (o_last)
    );

endmodule

>>> rtl/core/pida_ctrl.sv
// Controller state machine that sequences load, execute and dump steps.
`timescale 1ns / 1ps

module pida_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pida_pkg::t_dp_status  i_status,
    output pida_pkg::t_cmd        o_cmd
);

    pida_pkg::t_state r_state;
    pida_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pida_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.dump_step = 1'b0;
        busy            = 1'b1;
        case (r_state)
            pida_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = pida_pkg::S_EXEC;
                end
            end
            pida_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_dump && !i_status.empty) begin
                    n_state = pida_pkg::S_DUMP;
                end else begin
                    n_state = pida_pkg::S_IDLE;
                end
            end
            pida_pkg::S_DUMP: begin
                o_cmd.dump_step = 1'b1;
                if (i_status.dump_last) begin
                    n_state = pida_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pida_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/pida_dp.sv
// Datapath: list cells, element count, dump counter and result registers.
`timescale 1ns / 1ps

module pida_dp #(
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pida_pkg::t_cmd                         i_cmd,
    output pida_pkg::t_dp_status                   o_status_dp,
    input  logic [pida_pkg::MODE_W-1:0]            i_mode,
    input  logic [pida_pkg::INDEX_W-1:0]           i_index,
    input  logic signed [pida_pkg::VALUE_W-1:0]    i_value,
    output logic                                   o_strobe,
    output logic [pida_pkg::STATUS_W-1:0]          o_status,
    output logic signed [pida_pkg::VALUE_W-1:0]    o_element,
    output logic [pida_pkg::EIDX_W-1:0]            o_element_index,
    output logic [pida_pkg::COUNT_W-1:0]           o_count,
    output logic                                   o_last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CTRW = $clog2(DEPTH);
    localparam int CMPW = (CW > pida_pkg::INDEX_W) ? CW : pida_pkg::INDEX_W;

    // Transaction operands held for the execute cycle.
    logic [pida_pkg::MODE_W-1:0]         r_mode;
    logic [pida_pkg::INDEX_W-1:0]        r_index;
    logic [pida_pkg::VALUE_W-1:0]        r_value;

    logic [pida_pkg::VALUE_W-1:0]        r_cells [DEPTH];
    logic [pida_pkg::VALUE_W-1:0]        n_cells [DEPTH];
    logic [CW-1:0]                       r_cnt;
    logic [CW-1:0]                       n_cnt;
    logic [CTRW-1:0]                     r_ctr;
    logic [CTRW-1:0]                     n_ctr;

    logic                                r_strobe;
    logic                                n_strobe;
    logic [pida_pkg::STATUS_W-1:0]       r_status;
    logic [pida_pkg::STATUS_W-1:0]       n_status;
    logic [pida_pkg::VALUE_W-1:0]        r_element;
    logic [pida_pkg::VALUE_W-1:0]        n_element;
    logic [pida_pkg::EIDX_W-1:0]         r_eidx;
    logic [pida_pkg::EIDX_W-1:0]         n_eidx;
    logic                                r_last;
    logic                                n_last;
    logic [pida_pkg::COUNT_W-1:0]        r_count_o;

    logic [CMPW-1:0]                     idx_ext;
    logic [CMPW-1:0]                     cnt_ext;
    logic                                dump_last;

    assign idx_ext   = CMPW'(r_index);
    assign cnt_ext   = CMPW'(r_cnt);
    assign dump_last = ((CW'(r_ctr) + CW'(1)) == r_cnt);

    assign o_status_dp.is_dump   = (r_mode == pida_pkg::MODE_DUMP);
    assign o_status_dp.empty     = (r_cnt == '0);
    assign o_status_dp.dump_last = dump_last;

    always_comb begin
        n_cells   = r_cells;
        n_cnt     = r_cnt;
        n_ctr     = r_ctr;
        n_strobe  = 1'b0;
        n_status  = pida_pkg::STATUS_OK;
        n_element = '0;
        n_eidx    = '0;
        n_last    = 1'b1;
        if (i_cmd.exec) begin
            case (r_mode)
                pida_pkg::MODE_INSERT: begin
                    n_strobe = 1'b1;
                    if (idx_ext > cnt_ext) begin
                        n_status = pida_pkg::STATUS_RANGE;
                    end else if (r_cnt == CW'(DEPTH)) begin
                        n_status = pida_pkg::STATUS_FULL;
                    end else begin
                        for (int i = 1; i < DEPTH; i++) begin
                            if (CMPW'(i) > idx_ext) begin
                                n_cells[i] = r_cells[i-1];
                            end
                        end
                        for (int i = 0; i < DEPTH; i++) begin
                            if (CMPW'(i) == idx_ext) begin
                                n_cells[i] = r_value;
                            end
                        end
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                pida_pkg::MODE_DELETE: begin
                    n_strobe = 1'b1;
                    if (idx_ext >= cnt_ext) begin
                        n_status = pida_pkg::STATUS_RANGE;
                    end else begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            if (CMPW'(i) >= idx_ext) begin
                                n_cells[i] = r_cells[i+1];
                            end
                        end
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                pida_pkg::MODE_DUMP: begin
                    if (r_cnt == '0) begin
                        n_strobe = 1'b1;
                        n_status = pida_pkg::STATUS_EMPTY;
                    end else begin
                        n_ctr = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.dump_step) begin
            // The stored entries rotate down by one each step, so the head cell
            // is always the next one to send; after count steps the list is back
            // in its original order.
            n_strobe  = 1'b1;
            n_element = r_cells[0];
            n_eidx    = pida_pkg::EIDX_W'(r_ctr);
            n_last    = dump_last;
            n_ctr     = r_ctr + CTRW'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (CW'(i + 1) < r_cnt) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
            for (int i = 0; i < DEPTH; i++) begin
                if (CW'(i + 1) == r_cnt) begin
                    n_cells[i] = r_cells[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_index <= i_index;
            r_value <= i_value;
        end
        r_cells   <= n_cells;
        r_ctr     <= n_ctr;
        r_status  <= n_status;
        r_element <= n_element;
        r_eidx    <= n_eidx;
        r_last    <= n_last;
        r_count_o <= pida_pkg::COUNT_W'(n_cnt);
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_element       = r_element;
    assign o_element_index = r_eidx;
    assign o_count         = r_count_o;
    assign o_last          = r_last;

endmodule

>>> bench/pida_checker.sv
// Checker for the positional insert/delete list: predicts each transaction and compares results.
`timescale 1ns / 1ps

module pida_checker
    import pida_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_strobe,
    input  logic [STATUS_W-1:0]        i_status,
    input  logic signed [VALUE_W-1:0]  i_element,
    input  logic [EIDX_W-1:0]          i_element_index,
    input  logic [COUNT_W-1:0]         i_count,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] element;
        logic [EIDX_W-1:0]         element_index;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_list_result;

    logic signed [VALUE_W-1:0] list_cells [DEPTH];
    int                        list_count = 0;
    t_list_result              awaited_results [$];
    int                        fail_total = 0;

    function automatic t_list_result make_result(
        input logic [STATUS_W-1:0]       status,
        input logic signed [VALUE_W-1:0] element,
        input int                        position,
        input logic                      last
    );
        t_list_result r;
        r.status        = status;
        r.element       = element;
        r.element_index = EIDX_W'(position);
        r.count         = COUNT_W'(list_count);
        r.last          = last;
        return r;
    endfunction

    task automatic apply_list_op(
        input logic [MODE_W-1:0]          mode,
        input logic [INDEX_W-1:0]         index,
        input logic signed [VALUE_W-1:0]  value
    );
        int pos;
        int i;
        pos = int'(index);
        case (mode)
            MODE_INSERT: begin
                // The range check takes priority over the full check.
                if (pos > list_count) begin
                    awaited_results.push_back(make_result(STATUS_RANGE, '0, 0, 1'b1));
                end else if (list_count >= DEPTH) begin
                    awaited_results.push_back(make_result(STATUS_FULL, '0, 0, 1'b1));
                end else begin
                    for (i = list_count; i > pos; i--) list_cells[i] = list_cells[i-1];
                    list_cells[pos] = value;
                    list_count++;
                    awaited_results.push_back(make_result(STATUS_OK, '0, 0, 1'b1));
                end
            end
            MODE_DELETE: begin
                if (pos >= list_count) begin
                    awaited_results.push_back(make_result(STATUS_RANGE, '0, 0, 1'b1));
                end else begin
                    for (i = pos; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
                    list_count--;
                    awaited_results.push_back(make_result(STATUS_OK, '0, 0, 1'b1));
                end
            end
            MODE_DUMP: begin
                if (list_count == 0) begin
                    awaited_results.push_back(make_result(STATUS_EMPTY, '0, 0, 1'b1));
                end else begin
                    for (i = 0; i < list_count; i++) begin
                        awaited_results.push_back(
                            make_result(STATUS_OK, list_cells[i], i, i == list_count - 1));
                    end
                end
            end
            default: begin
                // The unused mode produces nothing and leaves the list alone.
            end
        endcase
    endtask

    task automatic check_result();
        t_list_result got;
        t_list_result want;
        got.status        = i_status;
        got.element       = i_element;
        got.element_index = i_element_index;
        got.count         = i_count;
        got.last          = i_last;
        if (awaited_results.size() == 0) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("unexpected result: status=%0d element=%0d index=%0d",
                         got.status, got.element, got.element_index);
                $display("                   count=%0d last=%0b", got.count, got.last);
            end
        end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.element !== want.element ||
                got.element_index !== want.element_index || got.count !== want.count ||
                got.last !== want.last) begin
                fail_total++;
                if (fail_total <= 10) begin
                    $display({"mismatch at %0t: exp status=%0d element=%0d index=%0d",
                              " count=%0d last=%0b"},
                             $realtime, want.status, want.element, want.element_index,
                             want.count, want.last);
                    $display({"                got status=%0d element=%0d index=%0d",
                              " count=%0d last=%0b"},
                             got.status, got.element, got.element_index, got.count, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_count = 0;
            awaited_results.delete();
        end else begin
            // Results are registered after their transaction is loaded and executed, so check them first.
            if (i_strobe) check_result();
            if (i_start && !i_busy) apply_list_op(i_mode, i_index, i_value);
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> bench/tb_positional_insert_delete_array.sv
// Testbench top for the positional insert/delete list: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_positional_insert_delete_array;
    import pida_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 260;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [MODE_W-1:0]          i_mode = '0;
    logic [INDEX_W-1:0]         i_index = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_strobe;
    logic [STATUS_W-1:0]        o_status;
    logic signed [VALUE_W-1:0]  o_element;
    logic [EIDX_W-1:0]          o_element_index;
    logic [COUNT_W-1:0]         o_count;
    logic                       o_last;

    int fail_count;
    int pending;
    int fill_level = 0;
    bit idle_on = 1'b1;

    positional_insert_delete_array #(.DEPTH(DEPTH)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_element       (o_element),
        .o_element_index (o_element_index),
        .o_count         (o_count),
        .o_last          (o_last)
    );

    pida_checker #(.DEPTH(DEPTH)) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_strobe        (o_strobe),
        .i_status        (o_status),
        .i_element       (o_element),
        .i_element_index (o_element_index),
        .i_count         (o_count),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Ends the run when neither a transaction nor a result has moved for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_rst_n && start && !busy) || o_strobe || !i_rst_n) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Drives one transaction, optionally after a random gap, and returns once it is accepted.
    task automatic issue_cmd(
        input logic [MODE_W-1:0]          mode,
        input logic [INDEX_W-1:0]         index,
        input logic signed [VALUE_W-1:0]  value
    );
        if (idle_on && $urandom_range(99) < 19) begin
            start   <= 1'b0;
            i_mode  <= MODE_W'($urandom);
            i_index <= INDEX_W'($urandom);
            i_value <= $urandom;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= mode;
        i_index <= index;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (mode == MODE_INSERT && int'(index) <= fill_level && fill_level < DEPTH) begin
            fill_level++;
        end else if (mode == MODE_DELETE && int'(index) < fill_level) begin
            fill_level--;
        end
    endtask

    initial begin : stimulus
        int counted;
        int pick;
        bit grow;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, both range checks, extreme values, unused mode.
        issue_cmd(MODE_DUMP,   6'd0,  rand_value());
        issue_cmd(MODE_DELETE, 6'd0,  rand_value());
        issue_cmd(MODE_INSERT, 6'd1,  32'sd1);
        issue_cmd(MODE_INSERT, 6'd0,  32'sh7FFF_FFFF);
        issue_cmd(MODE_INSERT, 6'd1,  32'sh8000_0000);
        issue_cmd(MODE_INSERT, 6'd0,  -32'sd1);
        issue_cmd(MODE_INSERT, 6'd2,  32'sd0);
        issue_cmd(MODE_INSERT, 6'd5,  32'sd5);
        issue_cmd(MODE_DUMP,   6'd63, rand_value());
        issue_cmd(MODE_DELETE, 6'd4,  rand_value());
        issue_cmd(MODE_DELETE, 6'd1,  rand_value());
        issue_cmd(MODE_UNUSED, 6'd63, rand_value());
        issue_cmd(MODE_INSERT, 6'd63, rand_value());
        issue_cmd(MODE_DELETE, 6'd63, rand_value());
        issue_cmd(MODE_DELETE, 6'd0,  rand_value());
        issue_cmd(MODE_DUMP,   6'd0,  rand_value());

        // Fill to capacity at random positions, then hit the full list.
        while (fill_level < DEPTH) begin
            issue_cmd(MODE_INSERT, INDEX_W'($urandom_range(0, fill_level)), rand_value());
        end
        issue_cmd(MODE_INSERT, 6'd33, rand_value());
        issue_cmd(MODE_INSERT, 6'd32, rand_value());
        issue_cmd(MODE_INSERT, 6'd0,  rand_value());
        issue_cmd(MODE_DUMP,   6'd0,  rand_value());
        issue_cmd(MODE_DELETE, 6'd32, rand_value());
        issue_cmd(MODE_DELETE, 6'd31, rand_value());
        issue_cmd(MODE_DELETE, 6'd0,  rand_value());

        // Random: alternating growth and shrink phases of mostly in-range commands.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_on = !(counted >= 120 && counted < 200);
            grow = ((counted / 48) % 2) == 0;
            pick = $urandom_range(99);
            if (pick < 8) begin
                mode  = MODE_W'($urandom_range(0, 3));
                index = INDEX_W'($urandom_range(0, 63));
            end else if (pick < 14) begin
                mode  = MODE_DUMP;
                index = INDEX_W'($urandom);
            end else if (pick < (grow ? 80 : 34)) begin
                mode  = MODE_INSERT;
                index = INDEX_W'($urandom_range(0, fill_level));
            end else begin
                mode  = MODE_DELETE;
                index = (fill_level == 0) ? '0 : INDEX_W'($urandom_range(0, fill_level - 1));
            end
            issue_cmd(mode, index, rand_value());
            if (mode != MODE_UNUSED) counted++;
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> positional_insert_delete_array.f
rtl/core/pida_pkg.sv
rtl/core/pida_ctrl.sv
rtl/core/pida_dp.sv
rtl/core/positional_insert_delete_array.sv
bench/pida_checker.sv
bench/tb_positional_insert_delete_array.sv
